// ===== src/gif_lzw_encoder_top_macros.svh =====
// Assertion macros for the encoder checker
`ifndef GIF_LZW_ENCODER_TOP_MACROS_SVH
`define GIF_LZW_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define GLE_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define GLE_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gle_pkg.sv =====
package gle_pkg;

  localparam int PIX_BITS     = 8;
  localparam int CODE_BITS    = 12;
  localparam int KEY_BITS     = CODE_BITS + PIX_BITS;
  localparam int ENTRY_BITS   = KEY_BITS + CODE_BITS;
  localparam int NEXT_BITS    = CODE_BITS + 1;
  localparam int MAX_CODES    = 4096;
  localparam int WIDTH_BITS   = 4;
  localparam int SIZE_LO      = 2;
  localparam int SIZE_HI      = 8;
  localparam int SIZE_RESET   = 8;

  localparam int ACC_BITS     = 24;
  localparam int PEND_BITS    = 5;

  localparam int BLOCK_BYTES  = 255;
  localparam int FILL_BITS    = 8;

  localparam int HASH_BITS    = 13;
  localparam int HASH_ENTRIES = 1 << HASH_BITS;
  localparam int HASH_SHIFT   = 11;
  localparam int HASH_PROD_W  = HASH_SHIFT + HASH_BITS;
  localparam logic [31:0] HASH_MUL32 = 32'h9E3779B1;
  localparam logic [HASH_PROD_W-1:0] HASH_MUL = HASH_MUL32[HASH_PROD_W-1:0];

  localparam int VROW_BITS    = 5;
  localparam int VROW_W       = 1 << VROW_BITS;
  localparam int VADDR_BITS   = HASH_BITS - VROW_BITS;
  localparam int VROWS        = 1 << VADDR_BITS;

  localparam int WORD_BYTES   = 8;
  localparam int WORD_BITS    = WORD_BYTES * 8;
  localparam int COUNT_BITS   = 4;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_IGN   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SEL_CUR   = 2'd0,
    SEL_CLEAR = 2'd1,
    SEL_STOP  = 2'd2
  } code_sel_t;

  typedef enum logic [1:0] {
    EMIT_LEN  = 2'd0,
    EMIT_DATA = 2'd1,
    EMIT_ZERO = 2'd2
  } emit_sel_t;

  typedef struct packed {
    func_t                func;
    logic [PIX_BITS-1:0]  pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]  out_word;
    logic [COUNT_BITS-1:0] out_count;
    logic                  out_last;
  } out_item_t;

  typedef struct packed {
    logic      cap_in;
    logic      start_init;
    logic      clr_step;
    logic      put_load;
    logic      put_shift;
    logic      key_load;
    logic      hash_load;
    logic      probe_rd;
    logic      probe_next;
    logic      hit_take;
    logic      add;
    logic      full_reset;
    logic      open_pix;
    logic      tail_byte;
    logic      drain_start;
    logic      drain_rd;
    logic      drain_next;
    logic      drain_end;
    logic      term_done;
    logic      emit;
    code_sel_t sel;
    emit_sel_t emit_sel;
  } gle_cmd_t;

  typedef struct packed {
    logic open;
    logic pend_ge8;
    logic pend_nz;
    logic fill_last;
    logic fill_nz;
    logic clr_last;
    logic probe_valid;
    logic probe_hit;
    logic table_full;
    logic drain_last;
  } gle_stat_t;

endpackage

// ===== src/gle_pack.sv =====
module gle_pack import gle_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           byte_valid,
  input  logic [7:0]     byte_data,
  input  logic           flush,
  input  logic           out_ready,
  output logic           byte_rdy,
  output logic           flush_rdy,
  output logic           out_valid,
  output out_item_t      out_data
);

  logic [WORD_BITS-1:0]  word_r, word_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  ov_r, ov_nxt;
  out_item_t             out_r, out_nxt;
  logic                  out_free;

  assign out_free  = !ov_r || out_ready;
  assign byte_rdy  = (cnt_r != COUNT_BITS'(WORD_BYTES)) || out_free;
  assign flush_rdy = (cnt_r == '0) || out_free;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_comb begin
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r && !out_ready;
    out_nxt  = out_r;
    if (byte_valid && byte_rdy) begin
      if (cnt_r == COUNT_BITS'(WORD_BYTES)) begin
        out_nxt  = '{out_word: word_r, out_count: cnt_r, out_last: 1'b0};
        ov_nxt   = 1'b1;
        word_nxt = WORD_BITS'(byte_data);
        cnt_nxt  = COUNT_BITS'(1);
      end else if (cnt_r == '0) begin
        word_nxt = WORD_BITS'(byte_data);
        cnt_nxt  = COUNT_BITS'(1);
      end else begin
        word_nxt[cnt_r[2:0]*8 +: 8] = byte_data;
        cnt_nxt = cnt_r + COUNT_BITS'(1);
      end
    end else if (flush && flush_rdy && (cnt_r != '0)) begin
      out_nxt = '{out_word: word_r, out_count: cnt_r, out_last: 1'b1};
      ov_nxt  = 1'b1;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

endmodule

// ===== src/gle_dpath.sv =====
module gle_dpath import gle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gle_cmd_t              cmd,
  input  logic [PIX_BITS-1:0]   in_pixel,
  input  logic                  cfg_we,
  input  logic [WIDTH_BITS-1:0] cfg_wdata,
  output gle_stat_t             st,
  output logic                  byte_valid,
  output logic [7:0]            byte_data
);

  logic [ENTRY_BITS-1:0] dict_mem [HASH_ENTRIES];
  logic [VROW_W-1:0]     vrow_mem [VROWS];
  logic [7:0]            blk_mem  [BLOCK_BYTES];

  logic [WIDTH_BITS-1:0] cfg_r, fs_r, fs_nxt, width_r, width_nxt;
  logic [PIX_BITS-1:0]   pix_r, pmask, pix_m;
  logic                  open_r, open_nxt;
  logic [CODE_BITS-1:0]  cur_r, cur_nxt;
  logic [NEXT_BITS-1:0]  next_r, next_nxt, code13, mask13, clr13;
  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic [PEND_BITS-1:0]  pend_r, pend_nxt;
  logic [FILL_BITS-1:0]  fill_r, fill_nxt, rd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [HASH_BITS-1:0]  h_r;
  logic [HASH_PROD_W-1:0] prod;
  logic [ENTRY_BITS-1:0] ent_r;
  logic [VROW_W-1:0]     vrow_r;
  logic [VADDR_BITS-1:0] clr_r;
  logic [7:0]            bdata_r;
  logic [WIDTH_BITS-1:0] clamp;

  always_comb begin
    if (cfg_r < WIDTH_BITS'(SIZE_LO))      clamp = WIDTH_BITS'(SIZE_LO);
    else if (cfg_r > WIDTH_BITS'(SIZE_HI)) clamp = WIDTH_BITS'(SIZE_HI);
    else                                   clamp = cfg_r;
  end

  assign pmask = PIX_BITS'((9'd1 << fs_r) - 9'd1);
  assign pix_m = pix_r & pmask;
  assign prod  = HASH_PROD_W'(key_r) * HASH_MUL;
  assign fs_nxt = cmd.start_init ? clamp : fs_r;
  assign clr13  = NEXT_BITS'(1) << fs_nxt;

  always_comb begin
    case (cmd.sel)
      SEL_CUR:   code13 = NEXT_BITS'(cur_r);
      SEL_CLEAR: code13 = NEXT_BITS'(1) << fs_r;
      SEL_STOP:  code13 = (NEXT_BITS'(1) << fs_r) + NEXT_BITS'(1);
      default:   code13 = '0;
    endcase
    mask13 = (NEXT_BITS'(1) << width_r) - NEXT_BITS'(1);
  end

  always_comb begin
    open_nxt  = open_r;
    cur_nxt   = cur_r;
    next_nxt  = next_r;
    width_nxt = width_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    fill_nxt  = fill_r;

    if (cmd.start_init || cmd.term_done) open_nxt = 1'b0;
    else if (cmd.open_pix)               open_nxt = 1'b1;

    if (cmd.start_init) cur_nxt = '0;
    else if (cmd.open_pix || cmd.add || cmd.full_reset) cur_nxt = CODE_BITS'(pix_m);
    else if (cmd.hit_take) cur_nxt = ent_r[CODE_BITS-1:0];

    if (cmd.start_init || cmd.full_reset) begin
      next_nxt  = clr13 + NEXT_BITS'(2);
      width_nxt = fs_nxt + WIDTH_BITS'(1);
    end else if (cmd.add) begin
      next_nxt = next_r + NEXT_BITS'(1);
      if (next_r == (NEXT_BITS'(1) << width_r)) width_nxt = width_r + WIDTH_BITS'(1);
    end

    if (cmd.start_init || cmd.term_done) begin
      acc_nxt  = '0;
      pend_nxt = '0;
    end else if (cmd.put_load) begin
      acc_nxt  = acc_r | (ACC_BITS'(code13 & mask13) << pend_r[2:0]);
      pend_nxt = pend_r + PEND_BITS'(width_r);
    end else if (cmd.put_shift) begin
      acc_nxt  = acc_r >> 8;
      pend_nxt = pend_r - PEND_BITS'(8);
    end

    if (cmd.start_init || cmd.term_done || cmd.drain_end) fill_nxt = '0;
    else if (cmd.put_shift || cmd.tail_byte)             fill_nxt = fill_r + FILL_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= WIDTH_BITS'(SIZE_RESET);
      fs_r    <= WIDTH_BITS'(SIZE_RESET);
      open_r  <= 1'b0;
      cur_r   <= '0;
      next_r  <= (NEXT_BITS'(1) << SIZE_RESET) + NEXT_BITS'(2);
      width_r <= WIDTH_BITS'(SIZE_RESET + 1);
      acc_r   <= '0;
      pend_r  <= '0;
      fill_r  <= '0;
      clr_r   <= '0;
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      fs_r    <= fs_nxt;
      open_r  <= open_nxt;
      cur_r   <= cur_nxt;
      next_r  <= next_nxt;
      width_r <= width_nxt;
      acc_r   <= acc_nxt;
      pend_r  <= pend_nxt;
      fill_r  <= fill_nxt;
      if (cmd.clr_step) clr_r <= clr_r + VADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in)      pix_r <= in_pixel;
    if (cmd.key_load)    key_r <= {cur_r, pix_m};
    if (cmd.hash_load)   h_r   <= prod[HASH_SHIFT +: HASH_BITS];
    else if (cmd.probe_next) h_r <= h_r + HASH_BITS'(1);
    if (cmd.drain_start) rd_r  <= '0;
    else if (cmd.drain_next) rd_r <= rd_r + FILL_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.add) dict_mem[h_r] <= {key_r, next_r[CODE_BITS-1:0]};
    if (cmd.probe_rd) begin
      ent_r  <= dict_mem[h_r];
      vrow_r <= vrow_mem[h_r[HASH_BITS-1:VROW_BITS]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      vrow_mem[clr_r] <= '0;
    end else if (cmd.add) begin
      vrow_mem[h_r[HASH_BITS-1:VROW_BITS]] <=
        vrow_r | (VROW_W'(1) << h_r[VROW_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_shift || cmd.tail_byte) blk_mem[fill_r] <= acc_r[7:0];
    if (cmd.drain_rd) bdata_r <= blk_mem[rd_r];
  end

  always_comb begin
    case (cmd.emit_sel)
      EMIT_LEN:  byte_data = fill_r;
      EMIT_DATA: byte_data = bdata_r;
      EMIT_ZERO: byte_data = 8'd0;
      default:   byte_data = 8'd0;
    endcase
  end

  assign byte_valid     = cmd.emit;
  assign st.open        = open_r;
  assign st.pend_ge8    = pend_r >= PEND_BITS'(8);
  assign st.pend_nz     = pend_r != '0;
  assign st.fill_last   = fill_r == FILL_BITS'(BLOCK_BYTES - 1);
  assign st.fill_nz     = fill_r != '0;
  assign st.clr_last    = &clr_r;
  assign st.probe_valid = vrow_r[h_r[VROW_BITS-1:0]];
  assign st.probe_hit   = ent_r[ENTRY_BITS-1 -: KEY_BITS] == key_r;
  assign st.table_full  = next_r >= NEXT_BITS'(MAX_CODES);
  assign st.drain_last  = rd_r == (fill_r - FILL_BITS'(1));

endmodule

// ===== src/gle_ctrl.sv =====
module gle_ctrl import gle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  func_t     in_func,
  input  gle_stat_t st,
  input  logic      byte_rdy,
  input  logic      flush_rdy,
  output logic      in_ready,
  output gle_cmd_t  cmd,
  output logic      flush
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_PIX0, S_HASH, S_PRD, S_PCK, S_ADD, S_FULL,
    S_PUTL, S_PUTB, S_DLEN, S_DRD, S_DEM,
    S_END0, S_END1, S_END2, S_END3, S_TERM, S_DONE
  } state_t;

  state_t    state_r, state_nxt, ret_r, ret_nxt;
  code_sel_t sel_r, sel_nxt;
  logic      dret_end_r, dret_end_nxt;
  func_t     func_r, func_nxt;

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    sel_nxt      = sel_r;
    dret_end_nxt = dret_end_r;
    func_nxt     = func_r;
    cmd          = '0;
    cmd.sel      = sel_r;
    in_ready     = 1'b0;
    flush        = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          case (func_r)
            FUNC_START: begin
              sel_nxt   = SEL_CLEAR;
              ret_nxt   = S_DONE;
              state_nxt = S_PUTL;
            end
            FUNC_PIXEL: state_nxt = S_DONE;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          func_nxt   = in_func;
          case (in_func)
            FUNC_START: begin
              cmd.start_init = 1'b1;
              state_nxt      = S_CLR;
            end
            FUNC_PIXEL: state_nxt = S_PIX0;
            FUNC_END:   state_nxt = S_END0;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_PIX0: begin
        if (!st.open) begin
          cmd.open_pix = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.key_load = 1'b1;
          state_nxt    = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_load = 1'b1;
        state_nxt     = S_PRD;
      end
      S_PRD: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = S_PCK;
      end
      S_PCK: begin
        if (!st.probe_valid) begin
          sel_nxt   = SEL_CUR;
          ret_nxt   = S_ADD;
          state_nxt = S_PUTL;
        end else if (st.probe_hit) begin
          cmd.hit_take = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PRD;
        end
      end
      S_ADD: begin
        if (st.table_full) begin
          sel_nxt   = SEL_CLEAR;
          ret_nxt   = S_FULL;
          state_nxt = S_PUTL;
        end else begin
          cmd.add   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_FULL: begin
        cmd.full_reset = 1'b1;
        state_nxt      = S_CLR;
      end
      S_PUTL: begin
        cmd.put_load = 1'b1;
        state_nxt    = S_PUTB;
      end
      S_PUTB: begin
        if (st.pend_ge8) begin
          cmd.put_shift = 1'b1;
          if (st.fill_last) begin
            dret_end_nxt = 1'b0;
            state_nxt    = S_DLEN;
          end
        end else begin
          state_nxt = ret_r;
        end
      end
      S_DLEN: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EMIT_LEN;
        if (byte_rdy) begin
          cmd.drain_start = 1'b1;
          state_nxt       = S_DRD;
        end
      end
      S_DRD: begin
        cmd.drain_rd = 1'b1;
        state_nxt    = S_DEM;
      end
      S_DEM: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EMIT_DATA;
        if (byte_rdy) begin
          if (st.drain_last) begin
            cmd.drain_end = 1'b1;
            state_nxt     = dret_end_r ? S_TERM : S_PUTB;
          end else begin
            cmd.drain_next = 1'b1;
            state_nxt      = S_DRD;
          end
        end
      end
      S_END0: begin
        if (st.open) begin
          sel_nxt   = SEL_CUR;
          ret_nxt   = S_END1;
          state_nxt = S_PUTL;
        end else begin
          state_nxt = S_END1;
        end
      end
      S_END1: begin
        sel_nxt   = SEL_STOP;
        ret_nxt   = S_END2;
        state_nxt = S_PUTL;
      end
      S_END2: begin
        cmd.tail_byte = st.pend_nz;
        state_nxt     = S_END3;
      end
      S_END3: begin
        if (st.fill_nz) begin
          dret_end_nxt = 1'b1;
          state_nxt    = S_DLEN;
        end else begin
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EMIT_ZERO;
        if (byte_rdy) begin
          cmd.term_done = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        flush = 1'b1;
        if (flush_rdy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      ret_r      <= S_DONE;
      sel_r      <= SEL_CUR;
      dret_end_r <= 1'b0;
      func_r     <= FUNC_IGN;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      sel_r      <= sel_nxt;
      dret_end_r <= dret_end_nxt;
      func_r     <= func_nxt;
    end
  end

endmodule

// ===== src/gif_lzw_encoder_top.sv =====
// GIF LZW image-data encoder.
// Input words (in_valid/in_ready, in_data) carry a function code and a pixel:
// start frame, pixel, or end of frame. Output words (out_valid/out_ready,
// out_data) carry up to eight packed stream bytes, first byte lowest, with
// out_last on the final word of each input word. cfg_we/cfg_wdata set the
// minimum code size, latched at each start; write it only while idle.
// One input word is worked on at a time; in_ready is high only when idle.
// A pixel that opens a string only sets the current code; one that extends
// it hashes the key and probes the dictionary RAM (read, then key compare),
// a slot further per mismatch; a miss sends the code and adds an entry, or
// on a full table a clear code. A sub-block drain sends the length, then
// each byte; a restart (start word or full table) and reset sweep the
// valid-bit RAM before taking input. A stalled receiver holds the word in
// the output register; the encoder fills the next word and waits only
// when both are full or a non-empty next word has to be flushed.
module gif_lzw_encoder_top import gle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [WIDTH_BITS-1:0] cfg_wdata
);

  gle_cmd_t  cmd;
  gle_stat_t st;
  logic      byte_valid, byte_rdy, flush, flush_rdy;
  logic [7:0] byte_data;

  gle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .st        (st),
    .byte_rdy  (byte_rdy),
    .flush_rdy (flush_rdy),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .flush     (flush)
  );

  gle_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_pixel   (in_data.pixel_index),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .st         (st),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  gle_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .flush      (flush),
    .out_ready  (out_ready),
    .byte_rdy   (byte_rdy),
    .flush_rdy  (flush_rdy),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

// ===== src/gle_chk.sv =====
`include "gif_lzw_encoder_top_macros.svh"

module gle_chk import gle_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `GLE_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word dropped or changed while stalled")
  `GLE_AST_IMP(a_out_count, out_valid, out_data.out_count != '0 && out_data.out_count <= COUNT_BITS'(WORD_BYTES), "byte count out of range")
  `GLE_AST_IMP(a_short_last, out_valid && out_data.out_count != COUNT_BITS'(WORD_BYTES), out_data.out_last, "short word not marked last")
  `GLE_AST_NXT(a_busy, in_valid && in_ready, !in_ready, "input taken while an item is in work")

endmodule

bind gif_lzw_encoder_top gle_chk u_chk (.*);

// ===== tb/gif_lzw_encoder_top_test.sv =====
`timescale 1ns / 1ps

module gif_lzw_encoder_top_test;
  import gle_pkg::*;

  class lzw_scoreboard;
    bit [31:0]   dict_entry[HASH_ENTRIES];
    bit          dict_used[HASH_ENTRIES];
    int unsigned cur_code, next_code, code_width, acc, nbits, fill;
    int unsigned size_reg, frame_size;
    bit          str_open;
    byte unsigned blk[BLOCK_BYTES];
    byte unsigned stream_bytes[$];
    out_item_t   pending_words[$];
    int          errors;

    function new();
      size_reg = SIZE_RESET;
      frame_size = SIZE_RESET;
      errors = 0;
      clear_dict();
      cur_code = 0;
      str_open = 0;
      clear_packer();
    endfunction

    function void clear_dict();
      foreach (dict_used[i]) dict_used[i] = 0;
      next_code = (1 << frame_size) + 2;
      code_width = frame_size + 1;
    endfunction

    function void clear_packer();
      acc = 0;
      nbits = 0;
      fill = 0;
    endfunction

    function int unsigned hash_of(int unsigned key);
      int unsigned prod;
      prod = key * 32'd2654435761;
      return (prod >> 11) % HASH_ENTRIES;
    endfunction

    function void push_block_byte(int unsigned b);
      if (fill < BLOCK_BYTES) blk[fill] = b[7:0];
      fill++;
      if (fill >= BLOCK_BYTES) begin
        stream_bytes.push_back(8'(BLOCK_BYTES));
        for (int i = 0; i < BLOCK_BYTES; i++) stream_bytes.push_back(blk[i]);
        fill = 0;
      end
    endfunction

    function void put_code(int unsigned code, int unsigned width);
      int unsigned total;
      total = nbits + width;
      acc |= (code & ((1 << width) - 1)) << nbits;
      while (total >= 8) begin
        push_block_byte(acc & 8'hFF);
        acc >>= 8;
        total -= 8;
      end
      nbits = total & 3'h7;
      acc &= 24'hFFFFFF;
    endfunction

    function bit dict_find(int unsigned key, output int unsigned code);
      int unsigned h;
      h = hash_of(key);
      code = 0;
      for (int n = 0; n < HASH_ENTRIES; n++) begin
        if (!dict_used[h]) return 0;
        if ((dict_entry[h] >> 12) == key) begin
          code = dict_entry[h] & 12'hFFF;
          return 1;
        end
        h = (h + 1) % HASH_ENTRIES;
      end
      return 0;
    endfunction

    function void dict_add(int unsigned key, int unsigned code);
      int unsigned h;
      h = hash_of(key);
      for (int n = 0; n < HASH_ENTRIES; n++) begin
        if (!dict_used[h]) begin
          dict_used[h] = 1;
          dict_entry[h] = (key << 12) | (code & 12'hFFF);
          return;
        end
        h = (h + 1) % HASH_ENTRIES;
      end
    endfunction

    function void encode_pixel(int unsigned pix);
      int unsigned p, key, code;
      p = pix & ((1 << frame_size) - 1);
      if (!str_open) begin
        cur_code = p;
        str_open = 1;
        return;
      end
      key = ((cur_code & 12'hFFF) << 8) | p;
      if (dict_find(key, code)) begin
        cur_code = code;
        return;
      end
      put_code(cur_code, code_width);
      if (next_code < MAX_CODES) begin
        if (next_code == (1 << code_width)) code_width++;
        dict_add(key, next_code);
        next_code++;
      end else begin
        put_code(1 << frame_size, code_width);
        clear_dict();
      end
      cur_code = p;
    endfunction

    function void encode_end();
      if (str_open) put_code(cur_code, code_width);
      put_code((1 << frame_size) + 1, code_width);
      if (nbits != 0 && fill < BLOCK_BYTES) begin
        blk[fill] = acc[7:0];
        fill++;
      end
      if (fill > 0) begin
        stream_bytes.push_back(fill[7:0]);
        for (int i = 0; i < fill; i++) stream_bytes.push_back(blk[i]);
      end
      stream_bytes.push_back(8'h00);
      clear_packer();
      str_open = 0;
    endfunction

    function void note_input(in_item_t item);
      int unsigned nw;
      out_item_t w;
      stream_bytes.delete();
      case (item.func)
        FUNC_START: begin
          frame_size = (size_reg < SIZE_LO) ? SIZE_LO :
                       (size_reg > SIZE_HI) ? SIZE_HI : size_reg;
          clear_packer();
          str_open = 0;
          cur_code = 0;
          clear_dict();
          put_code(1 << frame_size, code_width);
        end
        FUNC_PIXEL: encode_pixel(item.pixel_index);
        FUNC_END:   encode_end();
        default: ;
      endcase
      nw = (stream_bytes.size() + 7) / 8;
      for (int k = 0; k < nw; k++) begin
        w = '0;
        for (int j = 0; j < WORD_BYTES; j++) begin
          if (k * 8 + j < stream_bytes.size()) begin
            w.out_word[8*j +: 8] = stream_bytes[k*8 + j];
            w.out_count++;
          end
        end
        w.out_last = (k + 1 == nw);
        pending_words.push_back(w);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_words.size() == 0) begin
        $error("unexpected word: out_word %h out_count %0d out_last %0d",
               got.out_word, got.out_count, got.out_last);
        errors++;
        return;
      end
      exp = pending_words.pop_front();
      if (got.out_word !== exp.out_word) begin
        $error("out_word: expected %h actual %h", exp.out_word, got.out_word);
        errors++;
      end
      if (got.out_count !== exp.out_count) begin
        $error("out_count: expected %0d actual %0d", exp.out_count, got.out_count);
        errors++;
      end
      if (got.out_last !== exp.out_last) begin
        $error("out_last: expected %0d actual %0d", exp.out_last, got.out_last);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [WIDTH_BITS-1:0] cfg_wdata;

  lzw_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   stall_left = 0;
  int unsigned   stall_mode = 0;

  gif_lzw_encoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gif_lzw_encoder_top_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_word(func_t f, logic [PIX_BITS-1:0] pix);
    int unsigned gap;
    in_item_t item;
    item.func = f;
    item.pixel_index = pix;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
  endtask

  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_words.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(int unsigned v);
    drain_outputs();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[WIDTH_BITS-1:0];
    sb.size_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame(int unsigned npix, bit narrow);
    int unsigned r;
    send_word(FUNC_START, PIX_BITS'($urandom_range(0, 255)));
    for (int i = 0; i < npix; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2)      send_word(FUNC_IGN, PIX_BITS'($urandom_range(0, 255)));
      else if (r < 3) send_word(FUNC_START, PIX_BITS'($urandom_range(0, 255)));
      else if (r < 4) send_word(FUNC_END, PIX_BITS'($urandom_range(0, 255)));
      else if (narrow)
        send_word(FUNC_PIXEL, PIX_BITS'($urandom_range(0, 3) << $urandom_range(0, 6)));
      else            send_word(FUNC_PIXEL, PIX_BITS'($urandom_range(0, 255)));
    end
    send_word(FUNC_END, PIX_BITS'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned sizes[10] = '{2, 0, 15, 5, 1, 3, 8, 7, 4, 6};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_word(FUNC_PIXEL, 8'hFF);
    send_word(FUNC_IGN, 8'h00);
    send_word(FUNC_START, 8'h00);
    send_word(FUNC_PIXEL, 8'h00);
    send_word(FUNC_PIXEL, 8'hFF);
    send_word(FUNC_PIXEL, 8'h00);
    send_word(FUNC_PIXEL, 8'h00);
    send_word(FUNC_PIXEL, 8'h00);
    send_word(FUNC_PIXEL, 8'hFF);
    send_word(FUNC_PIXEL, 8'hFF);
    send_word(FUNC_END, 8'hFF);
    send_word(FUNC_END, 8'h00);
    send_word(FUNC_START, 8'hAA);
    send_word(FUNC_PIXEL, 8'h55);
    send_word(FUNC_PIXEL, 8'hAA);
    send_word(FUNC_START, 8'h55);
    send_word(FUNC_PIXEL, 8'hAA);
    send_word(FUNC_PIXEL, 8'h55);
    send_word(FUNC_END, 8'h00);

    foreach (sizes[s]) begin
      write_size(sizes[s]);
      random_frame($urandom_range(1, 10), (s % 2) == 0);
    end

    // push one frame past a full sub-block
    write_size(SIZE_HI);
    send_word(FUNC_START, 8'h00);
    for (int i = 0; i < 245; i++) send_word(FUNC_PIXEL, PIX_BITS'($urandom_range(0, 255)));
    send_word(FUNC_END, 8'h00);

    drain_outputs();
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("gif_lzw_encoder_top_test: PASS");
    else
      $display("gif_lzw_encoder_top_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/gle_pkg.sv
src/gle_pack.sv
src/gle_dpath.sv
src/gle_ctrl.sv
src/gif_lzw_encoder_top.sv
src/gle_chk.sv
tb/gif_lzw_encoder_top_test.sv
